### hdl/aes_pkg.sv
`default_nettype none
package aes_pkg;

  localparam int unsigned NumRounds  = 10;
  localparam int unsigned BlockBits  = 128;
  localparam int unsigned HalfBits   = 64;
  localparam int unsigned CfgIdxBits = 1;

  localparam logic [CfgIdxBits-1:0] RegKeyHigh = 1'b0;
  localparam logic [CfgIdxBits-1:0] RegKeyLow  = 1'b1;

  typedef logic [BlockBits-1:0] block_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte i of the block sits at bits [127-8i -: 8]
  function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
    get_byte = b[BlockBits-1-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BlockBits-1-8*(c*4+r) -: 8] = SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
      end
    end
    sub_shift = t;
  endfunction

  function automatic block_t mix_columns(input block_t s);
    block_t     t;
    logic [7:0] a0, a1, a2, a3, al;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, c*4);
      a1 = get_byte(s, c*4+1);
      a2 = get_byte(s, c*4+2);
      a3 = get_byte(s, c*4+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      t[BlockBits-1-8*(c*4)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      t[BlockBits-1-8*(c*4+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      t[BlockBits-1-8*(c*4+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      t[BlockBits-1-8*(c*4+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    mix_columns = t;
  endfunction

  // next round key from the previous one
  function automatic block_t next_key(input block_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    next_key = {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

### hdl/aes_key_sched.sv
`default_nettype none
module aes_key_sched #(
  parameter int unsigned NUM_ROUNDS = aes_pkg::NumRounds
) (
  input  wire                   clk_i,
  input  wire aes_pkg::block_t  key_i,
  output aes_pkg::block_t       rkey_o [NUM_ROUNDS+1]
);
  import aes_pkg::*;

  // round keys registered: key only changes while idle, pipeline drains first
  block_t rk_q [NUM_ROUNDS+1];

  always_comb begin
    for (int r = 0; r <= NUM_ROUNDS; r++) rkey_o[r] = rk_q[r];
  end

  always_ff @(posedge clk_i) begin
    rk_q[0] <= key_i;
    for (int r = 1; r <= NUM_ROUNDS; r++) begin
      rk_q[r] <= next_key(rk_q[r-1], RCON[r-1]);
    end
  end
endmodule
`default_nettype wire

### hdl/aes_round.sv
`default_nettype none
module aes_round (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   en_i,
  input  wire                   valid_i,
  input  wire                   last_i,
  input  wire aes_pkg::block_t  state_i,
  input  wire aes_pkg::block_t  rkey_i,
  output logic                  valid_o,
  output aes_pkg::block_t       state_o
);
  import aes_pkg::*;

  block_t sb;
  block_t state_d, state_q;
  logic   valid_q;

  always_comb begin
    sb      = sub_shift(state_i);
    state_d = (last_i ? sb : mix_columns(sb)) ^ rkey_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) state_q <= state_d;
  end

  assign valid_o = valid_q;
  assign state_o = state_q;
endmodule
`default_nettype wire

### hdl/aes128_block_encrypt_core.sv
// aes-128 encryption core, one 16-byte block per request
// channels:
//   s_axis: plaintext request, tdata low half plaintext_high, high half plaintext_low
//   m_axis: ciphertext result, tdata low half ciphertext_high, high half ciphertext_low
//   cfg:    key write, index 0 = key_high, index 1 = key_low
// the datapath is fully unrolled: an input stage doing the first key add,
// then one register stage per round; a block passes the input stage and
// each round stage in order before it is offered on m_axis, and a new
// block can enter every cycle unless stalled or held off for a key write
// round keys are expanded by a registered chain that is skewed like the
// data, so each stage sees its round key on time; cfg is ready only while
// the pipe is empty, input is held off while a key write is offered and
// in the cycle after it is taken, so the next block sees the new key
// reset clears all valid bits, sets the key to zero and holds input off
// for the first cycle
// when m_axis_tready is low with a result waiting the whole pipeline holds
// and s_axis_tready drops; nothing moves until the result is taken
`default_nettype none
module aes128_block_encrypt_core #(
  parameter int unsigned NUM_ROUNDS = aes_pkg::NumRounds
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // [63:0] plaintext_high, [127:64] plaintext_low
  input  wire  [aes_pkg::BlockBits-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // [63:0] ciphertext_high, [127:64] ciphertext_low
  output logic [aes_pkg::BlockBits-1:0]    m_axis_tdata,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [aes_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  wire  [aes_pkg::HalfBits-1:0]     cfg_data_i
);
  import aes_pkg::*;

  logic [HalfBits-1:0] key_hi_q, key_lo_q;
  block_t              rkey [NUM_ROUNDS+1];

  // pipeline stage 0 holds the block after the first key add
  logic   v [NUM_ROUNDS+1];
  block_t st [NUM_ROUNDS+1];
  logic   v0_q;
  block_t st0_q;
  logic   en;
  block_t pt_blk;
  logic   key_wait_q;
  logic   pipe_busy;

  // any block still in the pipe
  always_comb begin
    pipe_busy = 1'b0;
    for (int r = 0; r <= NUM_ROUNDS; r++) pipe_busy = pipe_busy | v[r];
  end

  assign cfg_ready_o = !pipe_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegKeyHigh: key_hi_q <= cfg_data_i;
        RegKeyLow:  key_lo_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // first round key catches up in the cycle after a key write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_wait_q <= 1'b1;
    end else begin
      key_wait_q <= cfg_valid_i && cfg_ready_o;
    end
  end

  aes_key_sched #(.NUM_ROUNDS(NUM_ROUNDS)) u_key_sched (
    .clk_i  (clk_i),
    .key_i  ({key_hi_q, key_lo_q}),
    .rkey_o (rkey)
  );

  // whole pipe advances together; stalls only when the output is full
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !key_wait_q && !cfg_valid_i;

  assign pt_blk = {s_axis_tdata[HalfBits-1:0], s_axis_tdata[BlockBits-1:HalfBits]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid && s_axis_tready;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) st0_q <= pt_blk ^ rkey[0];
  end

  assign v[0]  = v0_q;
  assign st[0] = st0_q;

  for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_round
    aes_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v[r-1]),
      .last_i  (r == NUM_ROUNDS),
      .state_i (st[r-1]),
      .rkey_i  (rkey[r]),
      .valid_o (v[r]),
      .state_o (st[r])
    );
  end

  assign m_axis_tvalid = v[NUM_ROUNDS];
  assign m_axis_tdata  = {st[NUM_ROUNDS][HalfBits-1:0],
                          st[NUM_ROUNDS][BlockBits-1:HalfBits]};

  // stalled result must hold until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed during stall");

  // input is never taken while the output stage is stuck
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
    else $error("input ready out of step with output stall");

  // an accepted block enters stage zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v0_q)
    else $error("accepted block lost at entry");

  // key writes never land while a result is offered on m_axis
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |-> !m_axis_tvalid)
    else $error("key written with blocks in flight");
endmodule
`default_nettype wire

### tb/tb.sv
`default_nettype none
module tb;
  import aes_pkg::*;

  localparam int unsigned SettleCycles = NumRounds + 10;
  localparam int unsigned DrainCycles  = 3 * (NumRounds + 1);
  localparam int unsigned WatchdogMax  = 5000;
  localparam int unsigned IdlePct      = 19;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // [63:0] plaintext_high, [127:64] plaintext_low
  logic [BlockBits-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // [63:0] ciphertext_high, [127:64] ciphertext_low
  logic [BlockBits-1:0]  m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i;
  logic [HalfBits-1:0]   cfg_data_i;

  aes128_block_encrypt_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // predictor copy of the key registers
  logic [HalfBits-1:0] key_hi_q, key_lo_q;
  logic [7:0]          sbox_tab [256];
  block_t              ciphertext_q [$];
  int unsigned         fail_cnt = 0;
  bit                  kat_bad;
  bit                  no_idle;      // disables random gaps on both sides
  int unsigned         hold_req;     // long receiver hold-off, in cycles
  int unsigned         quiet_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------
  // cipher predictor
  // ---------------------------------------------------------------
  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // substitution table from the field inverse plus the affine map
  task automatic build_sbox();
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = '0;
      for (int y = 1; y < 256 && x != 0; y++)
        if (gmul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sbox_tab[x] = s;
    end
  endtask

  function automatic logic [7:0] byte_at(input block_t b, input int i);
    return b[127-8*i -: 8];
  endfunction

  function automatic block_t encrypt_block(input block_t key, input block_t pt);
    block_t      rk, st, t;
    logic [31:0] w3, rw;
    logic [7:0]  rc, a0, a1, a2, a3;
    rk = key;
    rc = 8'h01;
    st = pt ^ rk;
    for (int rnd = 1; rnd <= NumRounds; rnd++) begin
      // byte substitution with row shift
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          t[127-8*(c*4+r) -: 8] = sbox_tab[byte_at(st, ((c + r) % 4) * 4 + r)];
      st = t;
      if (rnd != NumRounds) begin
        for (int c = 0; c < 4; c++) begin
          a0 = byte_at(st, c*4);   a1 = byte_at(st, c*4+1);
          a2 = byte_at(st, c*4+2); a3 = byte_at(st, c*4+3);
          t[127-8*(c*4)   -: 8] = gmul(a0, 8'h02) ^ gmul(a1, 8'h03) ^ a2 ^ a3;
          t[127-8*(c*4+1) -: 8] = a0 ^ gmul(a1, 8'h02) ^ gmul(a2, 8'h03) ^ a3;
          t[127-8*(c*4+2) -: 8] = a0 ^ a1 ^ gmul(a2, 8'h02) ^ gmul(a3, 8'h03);
          t[127-8*(c*4+3) -: 8] = gmul(a0, 8'h03) ^ a1 ^ a2 ^ gmul(a3, 8'h02);
        end
        st = t;
      end
      // next round key: rotate, substitute, round constant
      w3 = rk[31:0];
      rw = {sbox_tab[w3[23:16]] ^ rc, sbox_tab[w3[15:8]], sbox_tab[w3[7:0]],
            sbox_tab[w3[31:24]]};
      rk[127:96] ^= rw;
      rk[95:64]  ^= rk[127:96];
      rk[63:32]  ^= rk[95:64];
      rk[31:0]   ^= rk[63:32];
      rc = gmul(rc, 8'h02);
      st ^= rk;
    end
    return st;
  endfunction

  // ---------------------------------------------------------------
  // receiver: random stalls plus an optional long hold-off
  // ---------------------------------------------------------------
  int unsigned hold_left;
  bit          hold_taken;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
      hold_taken    <= 1'b0;
    end else if (hold_req != 0 && !hold_taken) begin
      hold_left     <= hold_req;
      hold_taken    <= 1'b1;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= (hold_left == 1);
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= IdlePct);
    end
  end

  // result checker: compare each accepted ciphertext with the oldest expectation
  block_t exp_ct;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (ciphertext_q.size() == 0) begin
        $display("%0t: result expected none actual %h", $time, m_axis_tdata);
        fail_cnt++;
      end else begin
        exp_ct = ciphertext_q.pop_front();
        if (m_axis_tdata[63:0] !== exp_ct[127:64]) begin
          $display("%0t: ciphertext_high expected %h actual %h", $time,
                   exp_ct[127:64], m_axis_tdata[63:0]);
          fail_cnt++;
        end
        if (m_axis_tdata[127:64] !== exp_ct[63:0]) begin
          $display("%0t: ciphertext_low expected %h actual %h", $time,
                   exp_ct[63:0], m_axis_tdata[127:64]);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog: too long without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cnt <= 0;
    else
      quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= WatchdogMax) begin
      $display("[aes128_block_encrypt_core] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // shared tasks
  // ---------------------------------------------------------------
  // one plaintext request; valid stays high afterwards for back-to-back traffic
  task automatic send_block(input block_t pt);
    block_t ct;
    ct = encrypt_block({key_hi_q, key_lo_q}, pt);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pt[63:0], pt[127:64]};
    do @(posedge clk_i); while (!s_axis_tready);
    ciphertext_q.push_back(ct);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (ciphertext_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // key writes only while idle, then let the round key chain settle
  task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
    drain();
    for (int i = 0; i < 2; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= (i == 0) ? RegKeyHigh : RegKeyLow;
      cfg_data_i  <= (i == 0) ? hi : lo;
      do @(posedge clk_i); while (!cfg_ready_o);
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    key_hi_q = hi;
    key_lo_q = lo;
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic block_t rand_block();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------
  // predictor sanity against the published vector, then reset-key traffic
  task automatic test_reset_key();
    block_t kat;
    kat = encrypt_block(128'h000102030405060708090a0b0c0d0e0f,
                        128'h00112233445566778899aabbccddeeff);
    if (kat !== 128'h69c4e0d86a7b0430d8cdb78070b4c55a) begin
      $display("%0t: known answer expected %h actual %h", $time,
               128'h69c4e0d86a7b0430d8cdb78070b4c55a, kat);
      kat_bad = 1'b1;
    end
    send_block('0);
    send_block('1);
    send_block({16{8'h55}});
    send_block({16{8'haa}});
  endtask

  // the published key, extreme keys, and all-zero, all-one and walking-one plaintexts
  task automatic test_directed();
    write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_block(128'h00112233445566778899aabbccddeeff);
    write_key('1, '1);
    send_block('0);
    send_block('1);
    for (int i = 0; i < 128; i += 17) send_block(block_t'(1) << i);
    write_key(64'h8000000000000000, 64'h0000000000000001);
    send_block('1);
    send_block(128'h1);
    send_block({1'b1, 127'b0});
  endtask

  task automatic test_random_keys();
    for (int k = 0; k < 10; k++) begin
      write_key({$urandom, $urandom}, {$urandom, $urandom});
      no_idle = (k == 4);
      for (int n = 0; n < 110; n++) send_block(rand_block());
    end
    no_idle = 1'b0;
  endtask

  // long receiver hold-off while the sender keeps pushing
  task automatic test_backpressure();
    write_key({$urandom, $urandom}, {$urandom, $urandom});
    hold_req = 300;
    for (int n = 0; n < 80; n++) send_block(rand_block());
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = RegKeyHigh;
    cfg_data_i    = '0;
    key_hi_q      = '0;
    key_lo_q      = '0;
    kat_bad       = 1'b0;
    no_idle       = 1'b0;
    hold_req      = 0;
    build_sbox();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SettleCycles) @(posedge clk_i);

    test_reset_key();
    test_directed();
    test_random_keys();
    test_backpressure();
    drain();

    if (fail_cnt == 0 && !kat_bad)
      $display("[aes128_block_encrypt_core] OK");
    else
      $display("[aes128_block_encrypt_core] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
